>>> rtl/core/normal_light_shade_macros.svh
// Assertion macros shared by the checker files.
`ifndef NORMAL_LIGHT_SHADE_MACROS_SVH
`define NORMAL_LIGHT_SHADE_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define NLS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define NLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/core/nls_pkg.sv
// ----------------------------------------------------------------------------
// nls_pkg
// Types and constants of the normal shading pipeline.
// ----------------------------------------------------------------------------
package nls_pkg;
  localparam int REG_W    = 48;
  localparam int LIGHT_W  = 16;
  localparam int NORM_W   = 16;
  localparam int SHADE_W  = 15;
  localparam int RED_W    = 16;
  localparam int Q_W      = 34;
  localparam int PP_W     = 64;
  localparam int T_W      = 66;
  localparam int SQ_W     = 50;
  localparam int IDX_W    = 3;
  localparam logic [SHADE_W-1:0] SHADE_ONE = 15'd16384;

  localparam logic [IDX_W-1:0] CFG_ROW_X = 3'd0;
  localparam logic [IDX_W-1:0] CFG_ROW_Y = 3'd1;
  localparam logic [IDX_W-1:0] CFG_ROW_Z = 3'd2;
  localparam logic [IDX_W-1:0] CFG_LIGHT = 3'd3;

  localparam logic [REG_W-1:0] ROW_X_RST = 48'd16384;
  localparam logic [REG_W-1:0] ROW_Y_RST = 48'd1073741824;
  localparam logic [REG_W-1:0] ROW_Z_RST = 48'd70368744177664;
  localparam logic [REG_W-1:0] LIGHT_RST = 48'd70368744177664;

  // Beat carried down the square-root cell chain.
  typedef struct packed {
    logic              valid;
    logic              zero;
    logic              sat;
    logic [PP_W-1:0]   pp;
    logic [Q_W-1:0]    q;
    logic [T_W-1:0]    t;
    logic [SQ_W-1:0]   sq;
    logic [SHADE_W-1:0] s;
  } nls_root_t;
endpackage

>>> rtl/core/nls_if.sv
// ----------------------------------------------------------------------------
// nls_if
// Valid/ready channels of the normal shading block.
// ----------------------------------------------------------------------------
interface nls_norm_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  modport source (output valid, normal_x, normal_y, normal_z, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

interface nls_shade_if;
  logic        valid;
  logic        ready;
  logic [14:0] shade;
  modport source (output valid, shade, input ready);
  modport sink   (input valid, shade, output ready);
endinterface

interface nls_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/normal_light_shade.sv
// ----------------------------------------------------------------------------
// normal_light_shade
// Lambert diffuse shade of a rotated, normalized vertex normal.
// ----------------------------------------------------------------------------
// Use: write the three matrix rows and the light vector on cfg_i (index 0..3,
// other indexes ignored; always ready) while the block is idle. Stream normals
// on norm_i, one beat per cycle; each yields one shade beat on shade_o.
// Pipeline: six front stages, fifteen root cells, one output register.
// Throughput: one normal per cycle while shade_o is not held; the root is
// resolved by a chain of fifteen cells, one shade bit per cell, all working on different beats.
// Stall: the whole pipeline advances only while the output register is empty
// or being taken, so norm_i.ready drops in the cycle shade_o is held.
// Reset: registers return to the identity matrix and light (0,0,1); all
// in-flight beats are dropped.
// ----------------------------------------------------------------------------
module normal_light_shade import nls_pkg::*; #(
  parameter int COEF_WIDTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  nls_norm_if.sink     norm_i,
  nls_shade_if.source  shade_o,
  nls_cfg_if.sink      cfg_i
);
  logic [REG_W-1:0] row_x_q, row_y_q, row_z_q, light_q;
  logic             en;
  logic             out_v_q;
  logic [SHADE_W-1:0] shade_q;
  nls_root_t        chain [16];

  assign en           = !out_v_q || shade_o.ready;
  assign norm_i.ready = en;
  assign cfg_i.ready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_x_q <= ROW_X_RST;
      row_y_q <= ROW_Y_RST;
      row_z_q <= ROW_Z_RST;
      light_q <= LIGHT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ROW_X: row_x_q <= cfg_i.data;
        CFG_ROW_Y: row_y_q <= cfg_i.data;
        CFG_ROW_Z: row_z_q <= cfg_i.data;
        CFG_LIGHT: light_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  nls_front #(.COEF_WIDTH(COEF_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (norm_i.valid),
    .nx_i    (norm_i.normal_x),
    .ny_i    (norm_i.normal_y),
    .nz_i    (norm_i.normal_z),
    .row_x_i (row_x_q),
    .row_y_i (row_y_q),
    .row_z_i (row_z_q),
    .light_i (light_q),
    .root_o  (chain[0])
  );

  for (genvar g = 0; g < SHADE_W; g++) begin : g_cell
    nls_root_cell #(.BIT(SHADE_W - 1 - g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .root_i (chain[g]),
      .root_o (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= chain[SHADE_W].valid;
    end
  end

  // Force zero when flagged; saturate anything at or past 1.0.
  always_ff @(posedge clk_i) begin
    if (en) begin
      priority if (chain[SHADE_W].zero) begin
        shade_q <= '0;
      end else if (chain[SHADE_W].sat || chain[SHADE_W].s[SHADE_W-1]) begin
        shade_q <= SHADE_ONE;
      end else begin
        shade_q <= chain[SHADE_W].s;
      end
    end
  end

  assign shade_o.valid = out_v_q;
  assign shade_o.shade = shade_q;
endmodule

>>> rtl/core/nls_front.sv
// ----------------------------------------------------------------------------
// nls_front
// Rotate, reduce to 16 bits, dot with light and square; feeds the root chain.
// ----------------------------------------------------------------------------
module nls_front import nls_pkg::*; #(
  parameter int COEF_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [NORM_W-1:0] nx_i,
  input  logic signed [NORM_W-1:0] ny_i,
  input  logic signed [NORM_W-1:0] nz_i,
  input  logic [REG_W-1:0]         row_x_i,
  input  logic [REG_W-1:0]         row_y_i,
  input  logic [REG_W-1:0]         row_z_i,
  input  logic [REG_W-1:0]         light_i,
  output nls_root_t                root_o
);
  localparam int PW  = (3 * COEF_WIDTH > REG_W) ? 3 * COEF_WIDTH : REG_W;
  localparam int PRW = COEF_WIDTH + NORM_W;
  localparam int DW  = PRW + 2;
  localparam int RW  = $clog2(DW);

  logic [PW-1:0] pad [3];
  logic signed [COEF_WIDTH-1:0] coef [3][3];
  logic signed [NORM_W-1:0] nv [3];
  logic signed [LIGHT_W-1:0] lv [3];

  logic [5:0] v_q;
  logic signed [PRW-1:0] prod_q [3][3];
  logic signed [DW-1:0]  d_q [3];
  logic [DW-1:0]         mg [3];
  logic [DW-1:0]         mor;
  logic [RW-1:0]         r;
  logic [RED_W-1:0]      m_q [3];
  logic                  neg_q [3];
  logic signed [RED_W:0] e [3];
  logic [2*RED_W-1:0]    sqr_q [3];
  logic signed [RED_W+LIGHT_W:0] pl_q [3];
  logic [Q_W-1:0]        q5_q, q6_q;
  logic signed [Q_W:0]   p5_q;
  logic [PP_W-1:0]       pp_q;
  logic                  zero_q, sat_q;

  assign pad[0] = PW'(row_x_i);
  assign pad[1] = PW'(row_y_i);
  assign pad[2] = PW'(row_z_i);
  assign nv[0] = nx_i;
  assign nv[1] = ny_i;
  assign nv[2] = nz_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        coef[i][k] = pad[i][k*COEF_WIDTH +: COEF_WIDTH];
      end
      lv[i] = light_i[i*LIGHT_W +: LIGHT_W];
    end
  end

  // Shift so the largest magnitude fits in 16 bits.
  always_comb begin
    mor = '0;
    r   = '0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = d_q[i][DW-1] ? DW'(-d_q[i]) : DW'(d_q[i]);
      mor   = mor | mg[i];
    end
    for (int b = RED_W; b < DW; b++) begin
      if (mor[b]) r = RW'(b - RED_W + 1);
    end
    for (int i = 0; i < 3; i++) begin
      e[i] = neg_q[i] ? -$signed({1'b0, m_q[i]}) : $signed({1'b0, m_q[i]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[i][k] <= PRW'(coef[i][k] * nv[k]);
        end
        d_q[i]   <= DW'(prod_q[i][0]) + DW'(prod_q[i][1]) + DW'(prod_q[i][2]);
        m_q[i]   <= RED_W'(mg[i] >> r);
        neg_q[i] <= d_q[i][DW-1];
        sqr_q[i] <= m_q[i] * m_q[i];
        pl_q[i]  <= (RED_W+LIGHT_W+1)'(e[i] * lv[i]);
      end
      q5_q   <= Q_W'(sqr_q[0]) + Q_W'(sqr_q[1]) + Q_W'(sqr_q[2]);
      p5_q   <= (Q_W+1)'(pl_q[0]) + (Q_W+1)'(pl_q[1]) + (Q_W+1)'(pl_q[2]);
      q6_q   <= q5_q;
      zero_q <= (q5_q == '0) || p5_q[Q_W] || (p5_q == '0);
      sat_q  <= !p5_q[Q_W] && (p5_q[Q_W-1:32] != '0);
      pp_q   <= p5_q[31:0] * p5_q[31:0];
    end
  end

  always_comb begin
    root_o       = '0;
    root_o.valid = v_q[5];
    root_o.zero  = zero_q;
    root_o.sat   = sat_q;
    root_o.pp    = pp_q;
    root_o.q     = q6_q;
  end
endmodule

>>> rtl/core/nls_root_cell.sv
// ----------------------------------------------------------------------------
// nls_root_cell
// Decide one bit of the shade: keep it while s*s*Q stays at or below P*P.
// ----------------------------------------------------------------------------
module nls_root_cell import nls_pkg::*; #(
  parameter int BIT = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  nls_root_t root_i,
  output nls_root_t root_o
);
  logic [T_W-1:0] cand;
  logic           take;
  nls_root_t      nxt;
  logic           valid_q;
  nls_root_t      data_q;

  // (s + 2^b)^2 Q = s^2 Q + 2^(b+1) sQ + 2^(2b) Q
  always_comb begin
    cand = root_i.t + (T_W'(root_i.sq) << (BIT + 1)) + (T_W'(root_i.q) << (2 * BIT));
    take = cand <= T_W'(root_i.pp);
    nxt  = root_i;
    if (take) begin
      nxt.t      = cand;
      nxt.sq     = root_i.sq + (SQ_W'(root_i.q) << BIT);
      nxt.s[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= nxt.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= nxt;
    end
  end

  always_comb begin
    root_o       = data_q;
    root_o.valid = valid_q;
  end
endmodule

>>> rtl/core/nls_checker.sv
// ----------------------------------------------------------------------------
// nls_checker
// Port-level checks of the normal shading block.
// ----------------------------------------------------------------------------
`include "normal_light_shade_macros.svh"

module nls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        norm_ready_i,
  input logic        shade_valid_i,
  input logic        shade_ready_i,
  input logic [14:0] shade_i,
  input logic        cfg_ready_i
);
  `NLS_ASSERT_NOW(a_shade_range, clk_i, rst_ni, shade_valid_i, shade_i <= 15'd16384, "shade above 1.0")
  `NLS_ASSERT_NEXT(a_shade_hold, clk_i, rst_ni, shade_valid_i && !shade_ready_i, shade_valid_i && $stable(shade_i), "stalled shade beat changed")
  `NLS_ASSERT_NOW(a_in_free, clk_i, rst_ni, !shade_valid_i || shade_ready_i, norm_ready_i, "input blocked with free output")
  `NLS_ASSERT_NOW(a_cfg_ready, clk_i, rst_ni, 1'b1, cfg_ready_i, "config port not ready")
endmodule

bind normal_light_shade nls_checker u_nls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .norm_ready_i  (norm_i.ready),
  .shade_valid_i (shade_o.valid),
  .shade_ready_i (shade_o.ready),
  .shade_i       (shade_o.shade),
  .cfg_ready_i   (cfg_i.ready)
);
